[hw/rtl/kcef_pkg.sv]
// kcef_pkg: shared types and constants of the key change event queue
// no dependencies; imported by kcef_scan, key_change_event_fifo_unit and tb
package kcef_pkg;

    localparam int LEVEL_W   = 10;
    localparam int KEY_COUNT = 10;
    localparam int KEY_W     = 4;
    localparam int EVENT_W   = KEY_W + 1;

    localparam logic [LEVEL_W-1:0] KEY_MASK  = LEVEL_W'((64'd1 << KEY_COUNT) - 64'd1);
    localparam logic [LEVEL_W-1:0] IDLE_INIT = 10'h3ff;
    localparam logic [KEY_W-1:0]   KEY_LAST  = KEY_W'(KEY_COUNT - 1);

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // one key step of the change scanner
    typedef struct packed {
        logic             active;
        logic             valid;
        logic             last;
        logic [KEY_W-1:0] key;
        logic             level;
    } push_t;

endpackage

[hw/rtl/kcef_ram.sv]
// kcef_ram: generic single-write, single-read RAM with registered read
// no dependencies
module kcef_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/kcef_scan.sv]
// kcef_scan: steps over the keys of one sample, one key per cycle
// depends on kcef_pkg
module kcef_scan
    import kcef_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LEVEL_W-1:0] changes,
    input  logic [LEVEL_W-1:0] levels,
    output push_t              push
);

    logic               busy_reg,    busy_next;
    logic [KEY_W-1:0]   idx_reg,     idx_next;
    logic [LEVEL_W-1:0] changes_reg;
    logic [LEVEL_W-1:0] levels_reg;
    logic               last;

    assign last = (idx_reg == KEY_LAST);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + KEY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            changes_reg <= changes;
            levels_reg  <= levels;
        end
    end

    assign push.active = busy_reg;
    assign push.valid  = busy_reg & changes_reg[idx_reg];
    assign push.last   = busy_reg & last;
    assign push.key    = idx_reg;
    assign push.level  = levels_reg[idx_reg];

endmodule

[hw/rtl/key_change_event_fifo_unit.sv]
// key_change_event_fifo_unit: key change detector feeding a circular event queue
// depends on kcef_pkg, kcef_ram, kcef_scan
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, func, key_levels      | request in
//  out      | out_valid, out_ready, event_valid,        | request out
//           | key_number, key_level                     |
//  cfg      | cfg_valid, cfg_ready, cfg_data            | write in
//
// a sample is accepted, then the scanner visits one key per cycle and
// writes at most one event per cycle through the single RAM write port
// a pop steps through accept, RAM read at the read pointer and output load
// reset empties the queue and loads the previous levels with all ones;
// the event RAM is not cleared
// the output register lets samples be taken while a result waits; a pop
// waits for the output register to drain before loading its result
module key_change_event_fifo_unit
    import kcef_pkg::*;
#(
    parameter int QUEUE_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [LEVEL_W-1:0] key_levels,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               event_valid,
    output logic [KEY_W-1:0]   key_number,
    output logic               key_level,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LEVEL_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

    state_t             state_reg,     state_next;
    logic [PTR_W-1:0]   rd_ptr_reg,    rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg,    wr_ptr_next;
    logic [LEVEL_W-1:0] prev_reg,      prev_next;
    logic               sampled_reg,   sampled_next;
    logic               empty_reg,     empty_next;
    logic               out_valid_reg, out_valid_next;
    logic               ev_valid_reg;
    logic [KEY_W-1:0]   key_num_reg;
    logic               key_lvl_reg;

    logic               in_acc;
    logic               out_free;
    logic               load_out;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_inc;
    logic               full;
    logic               ram_wr;
    logic               ram_rd;
    logic [EVENT_W-1:0] ram_rdata;
    logic [LEVEL_W-1:0] now_levels;
    logic               scan_start;
    push_t              push;

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_acc     = in_valid & in_ready;
    assign out_free   = ~out_valid_reg | out_ready;
    assign load_out   = (state_reg == S_OUT) & out_free;
    assign now_levels = key_levels & KEY_MASK;
    assign scan_start = in_acc & (func == FUNC_SAMPLE);

    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign full       = (wr_ptr_inc == rd_ptr_reg);
    // events that find the queue full are dropped
    assign ram_wr     = (state_reg == S_SCAN) & push.valid & ~full;
    assign ram_rd     = (state_reg == S_READ);

    kcef_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .changes (now_levels ^ prev_reg),
        .levels  (now_levels),
        .push    (push)
    );

    kcef_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data ({push.level, push.key}),
        .rd_en   (ram_rd),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        prev_next      = prev_reg;
        sampled_next   = sampled_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg & out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // idle levels only matter until the first sample
        if (cfg_valid & cfg_ready & ~sampled_reg)
        begin
            prev_next = cfg_data & KEY_MASK;
        end

        if (ram_wr)
        begin
            wr_ptr_next = wr_ptr_inc;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == FUNC_SAMPLE)
                    begin
                        prev_next    = now_levels;
                        sampled_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        empty_next = (rd_ptr_reg == wr_ptr_reg);
                        state_next = S_READ;
                    end
                end
            end
            S_SCAN:
            begin
                if (push.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (!empty_reg)
                    begin
                        rd_ptr_next = rd_ptr_inc;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            prev_reg      <= IDLE_INIT & KEY_MASK;
            sampled_reg   <= 1'b0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            prev_reg      <= prev_next;
            sampled_reg   <= sampled_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            ev_valid_reg <= ~empty_reg;
            key_num_reg  <= empty_reg ? '0 : ram_rdata[KEY_W-1:0];
            key_lvl_reg  <= empty_reg ? 1'b0 : ram_rdata[EVENT_W-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_valid_reg;
    assign key_number  = key_num_reg;
    assign key_level   = key_lvl_reg;

    // never overwrite the oldest unread event
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr |-> !full)
        else $error("event written into a full queue");

    // a non-empty pop must still find an event when its result loads
    a_pop_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !empty_reg) |-> (rd_ptr_reg != wr_ptr_reg))
        else $error("pop of an event from an empty queue");

    // scanner runs only while the control sits in the scan state
    a_scan_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        push.active |-> (state_reg == S_SCAN))
        else $error("scanner active outside the scan state");

    // an accepted pop goes to the RAM read cycle next
    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && func == FUNC_POP) |=> (state_reg == S_READ))
        else $error("accepted pop did not issue a RAM read");

    // the output register is loaded only when it is free
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == S_OUT) |=> (state_reg == S_OUT))
        else $error("pop result loaded over a waiting result");

endmodule

[bench/tb.sv]
// tb: self-checking bench for key_change_event_fifo_unit, the key change event queue
// depends on kcef_pkg and the unit's rtl; drives samples, pops and idle-level writes
// through valid/ready channels and checks every pop result against its own queue model
`timescale 1ns / 1ps

module tb;
    import kcef_pkg::*;

    localparam int QUEUE_SLOTS = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 15;
    localparam int PHASE_ITEMS = 245;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic             ev;
        logic [KEY_W-1:0] kn;
        logic             kl;
    } key_event_t;

    // queue model: previous levels, circular event store and the pop results still owed
    class key_event_scoreboard;
        logic [LEVEL_W-1:0] idle_lv;
        logic [LEVEL_W-1:0] prev_lv;
        bit                 took_sample;
        key_event_t         slot [QUEUE_SLOTS];
        int                 rd_ptr;
        int                 wr_ptr;
        key_event_t         owed [$];
        int                 errors;

        function new();
            idle_lv = IDLE_INIT;
            prev_lv = IDLE_INIT & KEY_MASK;
            took_sample = 1'b0;
            rd_ptr = 0;
            wr_ptr = 0;
            errors = 0;
        endfunction

        function void write_idle(logic [LEVEL_W-1:0] v);
            idle_lv = v;
            // only matters until the first sample
            if (!took_sample)
                prev_lv = v & KEY_MASK;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_input(logic f, logic [LEVEL_W-1:0] lv);
            logic [LEVEL_W-1:0] cur;
            logic [LEVEL_W-1:0] diff;
            key_event_t         e;
            int                 nxt;
            if (f == FUNC_SAMPLE)
            begin
                cur = lv & KEY_MASK;
                diff = cur ^ prev_lv;
                for (int k = 0; k < KEY_COUNT; k++)
                begin
                    if (diff[k])
                    begin
                        nxt = (wr_ptr + 1) % QUEUE_SLOTS;
                        // full queue drops the event
                        if (nxt != rd_ptr)
                        begin
                            e.ev = 1'b1;
                            e.kn = KEY_W'(k);
                            e.kl = cur[k];
                            slot[wr_ptr] = e;
                            wr_ptr = nxt;
                        end
                    end
                end
                prev_lv = cur;
                took_sample = 1'b1;
            end
            else if (rd_ptr == wr_ptr)
            begin
                e = '0;
                owed.push_back(e);
            end
            else
            begin
                owed.push_back(slot[rd_ptr]);
                rd_ptr = (rd_ptr + 1) % QUEUE_SLOTS;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic ev, logic [KEY_W-1:0] kn, logic kl);
            key_event_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("pop result with no pop request pending");
            end
            else
            begin
                want = owed.pop_front();
                if (ev !== want.ev)
                    report_mismatch($sformatf("event_valid %b, want %b", ev, want.ev));
                if (kn !== want.kn)
                    report_mismatch($sformatf("key_number %0d, want %0d", kn, want.kn));
                if (kl !== want.kl)
                    report_mismatch($sformatf("key_level %b, want %b", kl, want.kl));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = FUNC_SAMPLE;
    logic [LEVEL_W-1:0] key_levels = '0;
    logic               out_valid;
    logic               out_ready = 1'b1;
    logic               event_valid;
    logic [KEY_W-1:0]   key_number;
    logic               key_level;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEVEL_W-1:0] cfg_data = '0;

    key_event_scoreboard sb = new();
    bit                  quiet = 1'b0;
    int                  stall_cycles = 0;
    logic [LEVEL_W-1:0]  last_sample;

    key_change_event_fifo_unit #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key_levels  (key_levels),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_valid (event_valid),
        .key_number  (key_number),
        .key_level   (key_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(event_valid, key_number, key_level);
    end

    // watchdog on cycles with no request moving on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // receiver stalls in bursts, none once quiet
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send_request(input logic f, input logic [LEVEL_W-1:0] lv);
        in_valid <= 1'b1;
        func <= f;
        key_levels <= lv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(f, lv);
        if (f == FUNC_SAMPLE)
            last_sample = lv;
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_pop();
        send_request(FUNC_POP, LEVEL_W'($urandom_range(0, 1023)));
        maybe_gap();
    endtask

    task automatic send_sample(input logic [LEVEL_W-1:0] lv);
        send_request(FUNC_SAMPLE, lv);
        maybe_gap();
    endtask

    task automatic write_idle(input logic [LEVEL_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_idle(v);
    endtask

    // hold off until every pop result is back and the last scan is done, then write
    task automatic drain_and_write(input logic [LEVEL_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_idle(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int pop_pct);
        logic [LEVEL_W-1:0] lv;
        int                 r;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < pop_pct)
            begin
                send_pop();
            end
            else
            begin
                r = $urandom_range(0, 99);
                lv = last_sample;
                if (r >= 70)
                begin
                    lv = LEVEL_W'($urandom_range(0, 1023));
                end
                else if (r >= 15)
                begin
                    // a few keys toggle, like real key activity
                    repeat ($urandom_range(1, 3))
                        lv[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
                end
                send_sample(lv);
            end
        end
    endtask

    initial
    begin
        last_sample = IDLE_INIT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both extremes before the first sample; the second one sticks
        write_idle(10'h3ff);
        write_idle(10'h000);
        cfg_valid <= 1'b0;

        send_pop();
        send_sample(10'h000);
        send_sample(10'h3ff);
        repeat (8) send_pop();
        send_sample(10'h155);
        send_sample(10'h2aa);
        repeat (3) send_pop();
        send_sample(10'h200);
        repeat (8) send_pop();

        drain_and_write(LEVEL_W'($urandom_range(0, 1023)));
        random_phase(50);
        drain_and_write(10'h3ff);
        random_phase(35);
        drain_and_write(10'h000);
        random_phase(65);
        drain_and_write(LEVEL_W'($urandom_range(0, 1023)));
        random_phase(50);
        drain_and_write(LEVEL_W'($urandom_range(0, 1023)));
        quiet = 1'b1;
        random_phase(50);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
